>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define WDG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define WDG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/wdg_pkg.sv
// ----------------------------------------------------------------------------
// wdg_pkg
// Types, codes and constants shared by the grinder controller and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package wdg_pkg;

  // Sequence modes, as reported in mode_code.
  localparam logic [2:0] MODE_WAIT  = 3'd0;
  localparam logic [2:0] MODE_SET   = 3'd1;
  localparam logic [2:0] MODE_INIT  = 3'd2;
  localparam logic [2:0] MODE_FAST  = 3'd3;
  localparam logic [2:0] MODE_SLOW  = 3'd4;
  localparam logic [2:0] MODE_FINAL = 3'd5;
  localparam logic [2:0] MODE_ABORT = 3'd6;

  // Screens, as reported in display_mode.
  localparam logic [1:0] SCREEN_OFF    = 2'd0;
  localparam logic [1:0] SCREEN_WEIGHT = 2'd1;
  localparam logic [1:0] SCREEN_SET    = 2'd2;
  localparam logic [1:0] SCREEN_ABORT  = 2'd3;

  // Decoded button press.
  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_UP    = 2'd1;
  localparam logic [1:0] BTN_DOWN  = 2'd2;
  localparam logic [1:0] BTN_GRIND = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_SLOW_MARGIN     = 3'd0;
  localparam logic [2:0] REG_MAX_TARGET      = 3'd1;
  localparam logic [2:0] REG_MIN_TARGET      = 3'd2;
  localparam logic [2:0] REG_TARGET_STEP     = 3'd3;
  localparam logic [2:0] REG_SAFETY_LIMIT_MS = 3'd4;
  localparam logic [2:0] REG_DISPLAY_HOLD_MS = 3'd5;
  localparam logic [2:0] REG_SETUP_IDLE_MS   = 3'd6;

  // Register reset values.
  localparam logic [9:0]  RST_SLOW_MARGIN     = 10'd15;
  localparam logic [9:0]  RST_MAX_TARGET      = 10'd1000;
  localparam logic [9:0]  RST_MIN_TARGET      = 10'd20;
  localparam logic [7:0]  RST_TARGET_STEP     = 8'd1;
  localparam logic [15:0] RST_SAFETY_LIMIT_MS = 16'd35000;
  localparam logic [15:0] RST_DISPLAY_HOLD_MS = 16'd8000;
  localparam logic [15:0] RST_SETUP_IDLE_MS   = 16'd5000;

  // Target weight after reset, 0.1 g units.
  localparam logic [9:0] RST_TARGET = 10'd195;

  // Slow phase pulse halves, milliseconds.
  localparam logic [9:0] PULSE_ON_MS  = 10'd200;
  localparam logic [9:0] PULSE_OFF_MS = 10'd500;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] weight_sample;
    logic        grind_level;
    logic        down_level;
    logic        up_level;
    logic [9:0]  elapsed_ms;
  } wdg_in_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [2:0] pad;
    logic [2:0] mode_code;
    logic       save_strobe;
    logic [9:0] target_saved;
    logic [9:0] target_now;
    logic [1:0] display_mode;
    logic       scale_awake;
    logic       tare_request;
    logic       motor_on;
  } wdg_out_t;

endpackage

`default_nettype wire

>>> rtl/weigh_dose_grinder_controller.sv
// ----------------------------------------------------------------------------
// weigh_dose_grinder_controller
// Weigh-dose grinder sequencer: one control tick in, one set of controls out.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one control tick: the milliseconds since
// the previous tick, the three active-low button levels and the tared weight.
// Each tick produces exactly one request on the master stream with the motor,
// tare, scale power, display, target and save controls and the mode code.
// A tick is captured in an input register; once the result register is empty
// or being taken, the whole sequence step for it is evaluated in one pass and
// loaded into the result register, which offers it. One tick is taken in
// every cycle while results are being taken, and while the result register
// is full the input register still holds one further tick.
// If the receiver stalls, the result register holds its request unchanged and
// the input stops being ready only once both registers are full.
// The configuration port writes one register per enabled cycle; other indexes
// are ignored. The user writes only while no tick is in flight; unenforced.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults, puts the sequence in waiting with a 19.5 g target and
// treats all buttons as last seen low, so a released level is no press.
// ----------------------------------------------------------------------------
`default_nettype none

module weigh_dose_grinder_controller
  import wdg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Tick stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // Bits from 0: elapsed_ms[9:0], up_level, down_level, grind_level,
  // weight_sample[15:0], three zero bits.
  input  wire logic [31:0] s_tdata,
  // Control stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // Bits from 0: motor_on, tare_request, scale_awake, display_mode[1:0],
  // target_now[9:0], target_saved[9:0], save_strobe, mode_code[2:0],
  // three zero bits.
  output logic [31:0]      m_tdata,
  // Configuration write port.
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers.
  logic [9:0]  slow_margin;
  logic [9:0]  max_target;
  logic [9:0]  min_target;
  logic [7:0]  target_step;
  logic [15:0] safety_limit_ms;
  logic [15:0] display_hold_ms;
  logic [15:0] setup_idle_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_margin     <= RST_SLOW_MARGIN;
      max_target      <= RST_MAX_TARGET;
      min_target      <= RST_MIN_TARGET;
      target_step     <= RST_TARGET_STEP;
      safety_limit_ms <= RST_SAFETY_LIMIT_MS;
      display_hold_ms <= RST_DISPLAY_HOLD_MS;
      setup_idle_ms   <= RST_SETUP_IDLE_MS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SLOW_MARGIN:     slow_margin     <= cfg_data[9:0];
        REG_MAX_TARGET:      max_target      <= cfg_data[9:0];
        REG_MIN_TARGET:      min_target      <= cfg_data[9:0];
        REG_TARGET_STEP:     target_step     <= cfg_data[7:0];
        REG_SAFETY_LIMIT_MS: safety_limit_ms <= cfg_data;
        REG_DISPLAY_HOLD_MS: display_hold_ms <= cfg_data;
        REG_SETUP_IDLE_MS:   setup_idle_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register. Its tick moves into the result register when that register
  // is empty or being taken, and it empties then unless a new tick arrives.
  logic    in_valid;
  wdg_in_t in_item;
  logic    advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= wdg_in_t'(s_tdata);
    end
  end

  // Sequence state, advanced once per tick.
  logic [2:0]  mode;
  logic [9:0]  target_weight;
  logic [9:0]  saved_weight;
  logic [15:0] phase_timer;
  logic [9:0]  pulse_timer;
  logic        pulse_off;
  logic [2:0]  prev_levels;
  logic [1:0]  shown_screen;

  logic [2:0]  mode_next;
  logic [9:0]  target_weight_next;
  logic [9:0]  saved_weight_next;
  logic [15:0] phase_timer_next;
  logic [9:0]  pulse_timer_next;
  logic        pulse_off_next;
  logic [1:0]  shown_screen_next;
  logic [2:0]  levels;

  // Working signals of the tick evaluation.
  logic [2:0]         fell;
  logic [1:0]         btn;
  logic               was_slow;
  logic               tare;
  logic               save;
  logic               aborted;
  logic [16:0]        phase_sum;
  logic [10:0]        pulse_sum;
  logic signed [16:0] weight_ext;
  logic signed [16:0] target_ext;
  logic signed [16:0] fast_threshold;
  logic               fast_reached;
  logic               target_reached;
  logic [10:0]        up_sum;
  logic [10:0]        down_diff;
  wdg_out_t           result;

  assign levels         = {in_item.grind_level, in_item.down_level, in_item.up_level};
  assign fell           = prev_levels & ~levels;
  assign phase_sum      = {1'b0, phase_timer} + {7'd0, in_item.elapsed_ms};
  assign pulse_sum      = {1'b0, pulse_timer} + {1'b0, in_item.elapsed_ms};
  assign weight_ext     = 17'(signed'(in_item.weight_sample));
  assign target_ext     = signed'({7'd0, target_weight});
  assign fast_threshold = target_ext - signed'({7'd0, slow_margin});
  assign fast_reached   = weight_ext >= fast_threshold;
  assign target_reached = weight_ext >= target_ext;
  assign up_sum         = {1'b0, target_weight} + {3'd0, target_step};
  assign down_diff      = {1'b0, target_weight} - {3'd0, target_step};

  always_comb begin
    mode_next          = (mode > MODE_ABORT) ? MODE_WAIT : mode;
    target_weight_next = target_weight;
    saved_weight_next  = saved_weight;
    phase_timer_next   = phase_sum[16] ? 16'hFFFF : phase_sum[15:0];
    pulse_timer_next   = pulse_timer;
    pulse_off_next     = pulse_off;
    shown_screen_next  = shown_screen;
    tare               = 1'b0;
    save               = 1'b0;
    aborted            = 1'b0;

    // Grind beats up and down; up with down together is no press.
    btn = BTN_NONE;
    if (fell[1] && !fell[0]) btn = BTN_DOWN;
    if (fell[0] && !fell[1]) btn = BTN_UP;
    if (fell[2]) btn = BTN_GRIND;

    if (mode_next == MODE_WAIT || mode_next == MODE_FINAL) begin
      if (btn == BTN_UP || btn == BTN_DOWN) begin
        mode_next = MODE_SET;
      end else if (btn == BTN_GRIND) begin
        mode_next = MODE_INIT;
      end
    end else if (mode_next == MODE_SET) begin
      if (btn == BTN_GRIND) mode_next = MODE_INIT;
    end

    was_slow = (mode_next == MODE_SLOW);

    if (mode_next == MODE_INIT) begin
      tare             = 1'b1;
      phase_timer_next = '0;
      mode_next        = MODE_FAST;
    end

    if (mode_next == MODE_FAST) begin
      shown_screen_next = SCREEN_WEIGHT;
      if (fast_reached) begin
        mode_next        = MODE_SLOW;
        pulse_timer_next = '0;
        pulse_off_next   = 1'b0;
      end else if (phase_timer_next >= safety_limit_ms) begin
        mode_next = MODE_ABORT;
      end
    end

    // Slow phase: weight and timeout are looked at only at the end of an
    // off half, and time beyond a finished half is dropped.
    if (mode_next == MODE_SLOW && was_slow) begin
      shown_screen_next = SCREEN_WEIGHT;
      pulse_timer_next  = pulse_sum[10] ? 10'h3FF : pulse_sum[9:0];
      if (!pulse_off) begin
        if (pulse_timer_next >= PULSE_ON_MS) begin
          pulse_off_next   = 1'b1;
          pulse_timer_next = '0;
        end
      end else if (pulse_timer_next >= PULSE_OFF_MS) begin
        if (target_reached) begin
          mode_next        = MODE_FINAL;
          phase_timer_next = '0;
        end else if (phase_timer_next >= safety_limit_ms) begin
          mode_next = MODE_ABORT;
        end else begin
          pulse_off_next   = 1'b0;
          pulse_timer_next = '0;
        end
      end
    end

    if (mode_next == MODE_FINAL) begin
      if (phase_timer_next >= display_hold_ms) begin
        mode_next         = MODE_WAIT;
        shown_screen_next = SCREEN_OFF;
      end
    end

    // Abort is reported for this tick only; the hold starts next tick.
    if (mode_next == MODE_ABORT) begin
      aborted           = 1'b1;
      shown_screen_next = SCREEN_ABORT;
      phase_timer_next  = '0;
      mode_next         = MODE_FINAL;
    end

    if (mode_next == MODE_SET) begin
      if (btn == BTN_UP) begin
        target_weight_next = (up_sum > {1'b0, max_target}) ? max_target : up_sum[9:0];
        phase_timer_next   = '0;
      end else if (btn == BTN_DOWN) begin
        // Below the minimum, a negative difference included, clamps to it.
        target_weight_next = (down_diff[10] || down_diff[9:0] < min_target) ?
                             min_target : down_diff[9:0];
        phase_timer_next   = '0;
      end
      shown_screen_next = SCREEN_SET;
      if (phase_timer_next > setup_idle_ms) begin
        saved_weight_next = target_weight_next;
        save              = 1'b1;
        mode_next         = MODE_WAIT;
        shown_screen_next = SCREEN_OFF;
      end
    end

    result              = '0;
    result.motor_on     = (mode_next == MODE_FAST) ||
                          (mode_next == MODE_SLOW && !pulse_off_next);
    result.tare_request = tare;
    result.scale_awake  = (mode_next == MODE_FAST) || (mode_next == MODE_SLOW);
    result.display_mode = shown_screen_next;
    result.target_now   = target_weight_next;
    result.target_saved = saved_weight_next;
    result.save_strobe  = save;
    result.mode_code    = aborted ? MODE_ABORT : mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_WAIT;
      target_weight <= RST_TARGET;
      saved_weight  <= RST_TARGET;
      phase_timer   <= '0;
      pulse_timer   <= '0;
      pulse_off     <= 1'b0;
      prev_levels   <= '0;
      shown_screen  <= SCREEN_OFF;
    end else if (advance) begin
      mode          <= mode_next;
      target_weight <= target_weight_next;
      saved_weight  <= saved_weight_next;
      phase_timer   <= phase_timer_next;
      pulse_timer   <= pulse_timer_next;
      pulse_off     <= pulse_off_next;
      prev_levels   <= levels;
      shown_screen  <= shown_screen_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= 32'(result);
    end
  end

endmodule

`default_nettype wire

>>> rtl/wdg_checker.sv
// ----------------------------------------------------------------------------
// wdg_checker
// Port-level checks on the grinder controller's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wdg_checker
  import wdg_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  wdg_out_t res;
  logic     grinding;
  logic     save_ok;

  assign res      = wdg_out_t'(m_tdata);
  assign grinding = (res.mode_code == MODE_FAST) || (res.mode_code == MODE_SLOW);
  assign save_ok  = (res.mode_code == MODE_WAIT) && (res.target_now == res.target_saved);

  // The result register is empty after reset.
  `WDG_ASSERT_ALWAYS(a_empty_after_reset, (rst |=> !m_tvalid))

  // A stalled request keeps its controls.
  `WDG_ASSERT(a_stall_holds, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)))

  // The scale is powered in exactly the grinding phases, and the motor only then.
  `WDG_ASSERT(a_awake_in_grind, (m_tvalid |-> res.scale_awake == grinding))
  `WDG_ASSERT(a_motor_needs_scale, (m_tvalid && res.motor_on |-> res.scale_awake))

  // A save leaves set mode for waiting with the stored target matching.
  `WDG_ASSERT(a_save_consistent, (m_tvalid && res.save_strobe |-> save_ok))

endmodule

bind weigh_dose_grinder_controller wdg_checker u_wdg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/sv/weigh_dose_grinder_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grinder controller testbench
// Streams control ticks into the grinder controller and compares every
// control request that comes back against a cycle-free model of the grind,
// set-weight and display-hold sequence, kept in a small scoreboard class.
// ----------------------------------------------------------------------------

import wdg_pkg::*;

class grinder_scoreboard;
  logic [9:0]  slow_margin, max_target, min_target;
  logic [7:0]  target_step;
  logic [15:0] safety_ms, hold_ms, idle_ms;

  logic [2:0]  mode;
  logic [9:0]  target_wt, saved_wt;
  logic [15:0] phase_ms;
  logic [9:0]  pulse_ms;
  bit          pulse_off;
  logic [2:0]  prev_keys;
  logic [1:0]  screen;

  wdg_out_t    pending_controls[$];
  int          errors;

  function new();
    slow_margin = RST_SLOW_MARGIN;
    max_target  = RST_MAX_TARGET;
    min_target  = RST_MIN_TARGET;
    target_step = RST_TARGET_STEP;
    safety_ms   = RST_SAFETY_LIMIT_MS;
    hold_ms     = RST_DISPLAY_HOLD_MS;
    idle_ms     = RST_SETUP_IDLE_MS;
    mode        = MODE_WAIT;
    target_wt   = RST_TARGET;
    saved_wt    = RST_TARGET;
    phase_ms    = '0;
    pulse_ms    = '0;
    pulse_off   = 1'b0;
    prev_keys   = 3'b000;
    screen      = SCREEN_OFF;
    errors      = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      REG_SLOW_MARGIN:     slow_margin = val[9:0];
      REG_MAX_TARGET:      max_target  = val[9:0];
      REG_MIN_TARGET:      min_target  = val[9:0];
      REG_TARGET_STEP:     target_step = val[7:0];
      REG_SAFETY_LIMIT_MS: safety_ms   = val;
      REG_DISPLAY_HOLD_MS: hold_ms     = val;
      REG_SETUP_IDLE_MS:   idle_ms     = val;
      default: ;
    endcase
  endfunction

  // Advances the sequence by one accepted tick and queues the controls it gives.
  function void note_tick(wdg_in_t t);
    logic [2:0] keys, fell;
    logic [1:0] btn;
    int         el, w, sum;
    bit         tare, save, aborted, was_slow;
    wdg_out_t   r;
    el        = int'(t.elapsed_ms);
    w         = int'($signed(t.weight_sample));
    keys      = {t.grind_level, t.down_level, t.up_level};
    fell      = prev_keys & ~keys;
    prev_keys = keys;
    tare      = 1'b0;
    save      = 1'b0;
    aborted   = 1'b0;

    if (mode > MODE_ABORT) mode = MODE_WAIT;
    sum      = int'(phase_ms) + el;
    phase_ms = (sum > 65535) ? 16'hFFFF : sum[15:0];

    // Grind wins; up and down together cancel out.
    btn = BTN_NONE;
    if (fell[1] && !fell[0]) btn = BTN_DOWN;
    if (fell[0] && !fell[1]) btn = BTN_UP;
    if (fell[2]) btn = BTN_GRIND;

    if (mode == MODE_WAIT || mode == MODE_FINAL) begin
      if (btn == BTN_UP || btn == BTN_DOWN) mode = MODE_SET;
      else if (btn == BTN_GRIND) mode = MODE_INIT;
    end else if (mode == MODE_SET && btn == BTN_GRIND) begin
      mode = MODE_INIT;
    end

    was_slow = (mode == MODE_SLOW);

    if (mode == MODE_INIT) begin
      tare     = 1'b1;
      phase_ms = '0;
      mode     = MODE_FAST;
    end
    if (mode == MODE_FAST) begin
      screen = SCREEN_WEIGHT;
      if (w >= int'(target_wt) - int'(slow_margin)) begin
        mode      = MODE_SLOW;
        pulse_ms  = '0;
        pulse_off = 1'b0;
      end else if (phase_ms >= safety_ms) begin
        mode = MODE_ABORT;
      end
    end
    // Weight and timeout are looked at only when an off half has run out.
    if (mode == MODE_SLOW && was_slow) begin
      screen   = SCREEN_WEIGHT;
      sum      = int'(pulse_ms) + el;
      pulse_ms = (sum > 1023) ? 10'h3FF : sum[9:0];
      if (!pulse_off) begin
        if (pulse_ms >= PULSE_ON_MS) begin
          pulse_off = 1'b1;
          pulse_ms  = '0;
        end
      end else if (pulse_ms >= PULSE_OFF_MS) begin
        if (w >= int'(target_wt)) begin
          mode     = MODE_FINAL;
          phase_ms = '0;
        end else if (phase_ms >= safety_ms) begin
          mode = MODE_ABORT;
        end else begin
          pulse_off = 1'b0;
          pulse_ms  = '0;
        end
      end
    end
    if (mode == MODE_FINAL && phase_ms >= hold_ms) begin
      mode   = MODE_WAIT;
      screen = SCREEN_OFF;
    end
    if (mode == MODE_ABORT) begin
      aborted  = 1'b1;
      screen   = SCREEN_ABORT;
      phase_ms = '0;
      mode     = MODE_FINAL;
    end
    if (mode == MODE_SET) begin
      if (btn == BTN_UP) begin
        sum = int'(target_wt) + int'(target_step);
        if (sum > int'(max_target)) sum = int'(max_target);
        target_wt = sum[9:0];
        phase_ms  = '0;
      end else if (btn == BTN_DOWN) begin
        sum = int'(target_wt) - int'(target_step);
        if (sum < int'(min_target)) sum = int'(min_target);
        target_wt = sum[9:0];
        phase_ms  = '0;
      end
      screen = SCREEN_SET;
      if (phase_ms > idle_ms) begin
        saved_wt = target_wt;
        save     = 1'b1;
        mode     = MODE_WAIT;
        screen   = SCREEN_OFF;
      end
    end

    r              = '0;
    r.motor_on     = (mode == MODE_FAST) || (mode == MODE_SLOW && !pulse_off);
    r.tare_request = tare;
    r.scale_awake  = (mode == MODE_FAST) || (mode == MODE_SLOW);
    r.display_mode = screen;
    r.target_now   = target_wt;
    r.target_saved = saved_wt;
    r.save_strobe  = save;
    r.mode_code    = aborted ? MODE_ABORT : mode;
    pending_controls.push_back(r);
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_controls(wdg_out_t got);
    wdg_out_t want;
    if (pending_controls.size() == 0) begin
      $display("%0t: control request with no tick outstanding, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_controls.pop_front();
    compare_field("motor_on", 16'(want.motor_on), 16'(got.motor_on));
    compare_field("tare_request", 16'(want.tare_request), 16'(got.tare_request));
    compare_field("scale_awake", 16'(want.scale_awake), 16'(got.scale_awake));
    compare_field("display_mode", 16'(want.display_mode), 16'(got.display_mode));
    compare_field("target_now", 16'(want.target_now), 16'(got.target_now));
    compare_field("target_saved", 16'(want.target_saved), 16'(got.target_saved));
    compare_field("save_strobe", 16'(want.save_strobe), 16'(got.save_strobe));
    compare_field("mode_code", 16'(want.mode_code), 16'(got.mode_code));
  endfunction
endclass

module weigh_dose_grinder_controller_tb;
  // Cycles without any accepted request before the run is declared hung. The
  // longest legitimate quiet stretch is the receiver hold-off below.
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_TICKS     = 250;
  localparam int NUM_PHASES      = 8;
  localparam int PRESSURE_PHASE  = 3;

  // Button level bits as they sit in the tick: up, down, grind.
  localparam logic [2:0] KEY_UP        = 3'b001;
  localparam logic [2:0] KEY_DOWN      = 3'b010;
  localparam logic [2:0] KEY_GRIND     = 3'b100;
  localparam logic [2:0] KEYS_RELEASED = 3'b111;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_e;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  grinder_scoreboard sb = new();

  logic [2:0] keys;         // current button levels offered with each tick
  int         burst_left;   // ticks left before the sender may pause
  int         ticks_sent;
  int         idle_cycles;
  bit         steady_send;  // suppresses sender gaps
  bit         hold_req;     // asks the receiver for one long hold-off

  weigh_dose_grinder_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Both sides are sampled at the rising edge, before the block's own updates
  // take effect, so a request counts exactly when the handshake completes.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_tick(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_controls(m_tdata);
  end

  // The watchdog restarts whenever a request moves on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: segments of random length, each with its own ready pattern, and
  // one long hold-off on request so that the block backs up into its input.
  initial begin
    rx_pattern_e pat;
    int          seg_left;
    int          period;
    m_tready = 1'b0;
    seg_left = 0;
    period   = 2;
    pat      = RX_ALWAYS;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          pat      = rx_pattern_e'($urandom_range(0, 3));
          seg_left = $urandom_range(5, 80);
          period   = $urandom_range(2, 5);
        end
        case (pat)
          RX_ALWAYS:   m_tready <= 1'b1;
          RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: m_tready <= (seg_left % period == 0);
          default:     m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        seg_left--;
        @(posedge clk);
      end
    end
  end

  // Mostly short gaps between ticks, with a rare full-range value.
  function automatic int pick_ms();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return $urandom_range(0, 1023);
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  // Offers one tick with the current button levels and waits until it is taken.
  // The sender works in bursts; between bursts it may drop valid for a while.
  task automatic offer_tick(input int el, input int w);
    wdg_in_t t;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady_send && $urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    t               = '0;
    t.elapsed_ms    = el[9:0];
    t.up_level      = keys[0];
    t.down_level    = keys[1];
    t.grind_level   = keys[2];
    t.weight_sample = w[15:0];
    s_tdata  <= t;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    ticks_sent++;
  endtask

  // A press is a released level followed by a pressed one.
  task automatic press(input logic [2:0] mask, input int el, input int w);
    keys = keys | mask;
    offer_tick(el, w);
    keys = keys & ~mask;
    offer_tick(el, w);
  endtask

  // One grind: press, then a weight that climbs towards the target over a random
  // number of ticks. A share of runs never gains weight, to reach the timeout.
  task automatic grind_run();
    int n, w, tgt;
    bit stuck;
    tgt   = int'(sb.target_wt);
    stuck = ($urandom_range(0, 4) == 0);
    n     = stuck ? $urandom_range(20, 80) : $urandom_range(3, 60);
    w     = int'($urandom_range(0, 60)) - 40;
    keys  = KEYS_RELEASED;
    press(KEY_GRIND, pick_ms(), w);
    if ($urandom_range(0, 1) != 0) keys = KEYS_RELEASED;
    repeat (n) begin
      if (!stuck) w += $urandom_range(0, 2 * tgt / n + 3);
      // Stray button activity, ignored while the grind is running.
      if ($urandom_range(0, 19) == 0) keys = 3'($urandom_range(0, 7));
      offer_tick(stuck ? $urandom_range(300, 1023) : pick_ms(), w);
    end
    keys = KEYS_RELEASED;
    repeat ($urandom_range(0, 12)) offer_tick($urandom_range(0, 1023), w);
  endtask

  // Set-weight session: a few up, down, both-together or grind presses, then
  // idle ticks that may let the idle timeout save the target.
  task automatic set_run();
    int         w;
    logic [2:0] mask;
    w    = int'($urandom_range(0, 200)) - 100;
    keys = KEYS_RELEASED;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0:          mask = KEY_UP | KEY_DOWN;
        1:          mask = KEY_GRIND;
        2, 3, 4, 5: mask = KEY_UP;
        default:    mask = KEY_DOWN;
      endcase
      press(mask, $urandom_range(0, 400), w);
    end
    keys = KEYS_RELEASED;
    repeat ($urandom_range(0, 15)) offer_tick($urandom_range(0, 1023), w);
  endtask

  task automatic noise_run();
    repeat ($urandom_range(1, 8)) begin
      keys = 3'($urandom_range(0, 7));
      offer_tick($urandom_range(0, 1023), $urandom_range(0, 65535));
    end
    keys = KEYS_RELEASED;
  endtask

  task automatic set_reg(input logic [2:0] idx, input int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    sb.write_reg(idx, val[15:0]);
    @(posedge clk);
  endtask

  // Stops offering and waits until every control request has been returned.
  // The first edge lets the last accepted tick reach the scoreboard.
  task automatic drain();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_controls.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Phase one pushes every register to one extreme, phase two to the other
  // (with the clamps crossed over); later phases draw settings at random.
  task automatic configure(input int p);
    case (p)
      1: begin
        set_reg(REG_SLOW_MARGIN, 1023);
        set_reg(REG_MAX_TARGET, 1023);
        set_reg(REG_MIN_TARGET, 0);
        set_reg(REG_TARGET_STEP, 255);
        set_reg(REG_SAFETY_LIMIT_MS, 0);
        set_reg(REG_DISPLAY_HOLD_MS, 0);
        set_reg(REG_SETUP_IDLE_MS, 0);
      end
      2: begin
        set_reg(REG_SLOW_MARGIN, 0);
        set_reg(REG_MAX_TARGET, 0);
        set_reg(REG_MIN_TARGET, 1023);
        set_reg(REG_TARGET_STEP, 1);
        set_reg(REG_SAFETY_LIMIT_MS, 65535);
        set_reg(REG_DISPLAY_HOLD_MS, 65535);
        set_reg(REG_SETUP_IDLE_MS, 65535);
      end
      default: begin
        set_reg(REG_SLOW_MARGIN, ($urandom_range(0, 3) == 0) ?
                $urandom_range(0, 1023) : $urandom_range(0, 150));
        set_reg(REG_MAX_TARGET, ($urandom_range(0, 3) == 0) ?
                $urandom_range(0, 1023) : $urandom_range(300, 1023));
        set_reg(REG_MIN_TARGET, ($urandom_range(0, 3) == 0) ?
                $urandom_range(0, 1023) : $urandom_range(0, 300));
        set_reg(REG_TARGET_STEP, ($urandom_range(0, 1) == 0) ?
                $urandom_range(1, 255) : $urandom_range(1, 20));
        set_reg(REG_SAFETY_LIMIT_MS, ($urandom_range(0, 3) == 0) ?
                $urandom_range(0, 65535) : $urandom_range(500, 8000));
        set_reg(REG_DISPLAY_HOLD_MS, ($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 65535) : $urandom_range(0, 3000));
        set_reg(REG_SETUP_IDLE_MS, ($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 65535) : $urandom_range(0, 3000));
      end
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int p;
    int base;
    int sel;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    keys        = KEYS_RELEASED;
    burst_left  = 0;
    ticks_sent  = 0;
    idle_cycles = 0;
    steady_send = 1'b0;
    hold_req    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening with the reset settings. Buttons released after reset
    // are no press; then a single up and a single down step the target, up and
    // down together do nothing, and full-length ticks run out the idle time so
    // the target is saved.
    offer_tick(0, 0);
    press(KEY_UP, 100, 0);
    press(KEY_DOWN, 100, 0);
    press(KEY_UP | KEY_DOWN, 100, 0);
    keys = KEYS_RELEASED;
    repeat (5) offer_tick(1023, 0);
    // A full grind at the weight extremes: most negative reading in the fast
    // phase, then the largest one, through one on and one off pulse half into
    // the display hold, which then runs out.
    press(KEY_GRIND, 0, -32768);
    offer_tick(1023, -32768);
    offer_tick(10, 32767);
    offer_tick(200, 32767);
    offer_tick(500, 32767);
    keys = KEYS_RELEASED;
    repeat (8) offer_tick(1023, 0);

    base = ticks_sent;
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        drain();
        configure(p);
      end
      if (p == PRESSURE_PHASE) begin
        // The receiver holds off while the sender keeps offering back to back.
        hold_req    = 1'b1;
        steady_send = 1'b1;
        repeat (40) offer_tick(pick_ms(), $urandom_range(0, 400));
        steady_send = 1'b0;
      end
      while (ticks_sent < base + (p + 1) * PHASE_TICKS) begin
        sel = $urandom_range(0, 19);
        if (sel < 3) noise_run();
        else if (sel < 8) set_run();
        else grind_run();
      end
    end

    drain();
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/wdg_pkg.sv
rtl/weigh_dose_grinder_controller.sv
rtl/wdg_checker.sv
tb/sv/weigh_dose_grinder_controller_tb.sv
